/* sv/sfpds_pkg.sv */
// ----------------------------------------------------------------------------
// sfpds_pkg
// Shared types for the serial frame parser with dual running checksum.
// ----------------------------------------------------------------------------
`default_nettype none

package sfpds_pkg;

    localparam int BYTE_W  = 8;
    localparam int PHASE_W = 4;

    // One result item as it leaves the parser.
    typedef struct packed {
        logic              payload_strobe;
        logic [BYTE_W-1:0] payload_data;
        logic [BYTE_W-1:0] payload_index;
        logic              frame_good;
        logic              frame_bad;
        logic [BYTE_W-1:0] frame_type;
        logic [BYTE_W-1:0] frame_id;
        logic [BYTE_W-1:0] frame_length;
    } result_t;

endpackage

`default_nettype wire

/* sv/sfpds_parse.sv */
// ----------------------------------------------------------------------------
// sfpds_parse
// Frame state machine and running sums; computes the result for one byte.
// ----------------------------------------------------------------------------
`default_nettype none

module sfpds_parse
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          advance,
    input  wire logic [sfpds_pkg::BYTE_W-1:0]  rx_byte,
    output sfpds_pkg::result_t                 result
);

    localparam logic [sfpds_pkg::PHASE_W-1:0] PH_HUNT    = 4'd0;
    localparam logic [sfpds_pkg::PHASE_W-1:0] PH_ADDR    = 4'd1;
    localparam logic [sfpds_pkg::PHASE_W-1:0] PH_TYPE    = 4'd2;
    localparam logic [sfpds_pkg::PHASE_W-1:0] PH_ID      = 4'd3;
    localparam logic [sfpds_pkg::PHASE_W-1:0] PH_LEN     = 4'd4;
    localparam logic [sfpds_pkg::PHASE_W-1:0] PH_PAYLOAD = 4'd5;
    localparam logic [sfpds_pkg::PHASE_W-1:0] PH_CK_FLET = 4'd6;
    localparam logic [sfpds_pkg::PHASE_W-1:0] PH_CK_SUM  = 4'd7;
    localparam logic [sfpds_pkg::PHASE_W-1:0] PH_END     = 4'd8;

    localparam logic [7:0] START_BYTE = 8'hA5;
    localparam logic [7:0] ADDR_BYTE  = 8'h01;

    logic [sfpds_pkg::PHASE_W-1:0] phase_reg, phase_next;
    logic [7:0] type_reg, type_next;
    logic [7:0] id_reg, id_next;
    logic [7:0] len_reg, len_next;
    logic [7:0] pos_reg, pos_next;
    logic [7:0] sum_reg, sum_next;
    logic [7:0] flet_reg, flet_next;
    logic [7:0] rxflet_reg, rxflet_next;

    logic [7:0] sum_acc;
    logic [7:0] flet_acc;
    logic       last_payload;

    assign sum_acc      = sum_reg + rx_byte;
    assign flet_acc     = flet_reg + sum_acc;
    assign last_payload = ({1'b0, pos_reg} + 9'd1) >= {1'b0, len_reg};

    always_comb
    begin
        phase_next  = phase_reg;
        type_next   = type_reg;
        id_next     = id_reg;
        len_next    = len_reg;
        pos_next    = pos_reg;
        sum_next    = sum_reg;
        flet_next   = flet_reg;
        rxflet_next = rxflet_reg;

        result = '0;

        unique case (phase_reg)
            PH_ADDR:
            begin
                if (rx_byte == ADDR_BYTE)
                begin
                    sum_next   = sum_acc;
                    flet_next  = flet_acc;
                    phase_next = PH_TYPE;
                end
                else
                begin
                    phase_next = PH_HUNT;
                end
            end
            PH_TYPE:
            begin
                type_next  = rx_byte;
                sum_next   = sum_acc;
                flet_next  = flet_acc;
                phase_next = PH_ID;
            end
            PH_ID:
            begin
                id_next    = rx_byte;
                sum_next   = sum_acc;
                flet_next  = flet_acc;
                phase_next = PH_LEN;
            end
            PH_LEN:
            begin
                len_next   = rx_byte;
                sum_next   = sum_acc;
                flet_next  = flet_acc;
                pos_next   = '0;
                phase_next = (rx_byte == 8'd0) ? PH_CK_FLET : PH_PAYLOAD;
            end
            PH_PAYLOAD:
            begin
                sum_next              = sum_acc;
                flet_next             = flet_acc;
                result.payload_strobe = 1'b1;
                result.payload_data   = rx_byte;
                result.payload_index  = pos_reg;
                if (last_payload)
                begin
                    pos_next   = '0;
                    phase_next = PH_CK_FLET;
                end
                else
                begin
                    pos_next = pos_reg + 8'd1;
                end
            end
            PH_CK_FLET:
            begin
                rxflet_next = rx_byte;
                phase_next  = PH_CK_SUM;
            end
            PH_CK_SUM:
            begin
                if (rx_byte == sum_reg && rxflet_reg == flet_reg)
                    result.frame_good = 1'b1;
                else
                    result.frame_bad = 1'b1;
                phase_next = PH_END;
            end
            PH_END:
            begin
                phase_next = PH_HUNT;
            end
            default:
            begin
                // Hunting; unused phase codes behave the same way.
                if (rx_byte == START_BYTE)
                begin
                    sum_next   = rx_byte;
                    flet_next  = rx_byte;
                    phase_next = PH_ADDR;
                end
                else
                begin
                    phase_next = PH_HUNT;
                end
            end
        endcase

        result.frame_type   = type_next;
        result.frame_id     = id_next;
        result.frame_length = len_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HUNT;
            type_reg   <= '0;
            id_reg     <= '0;
            len_reg    <= '0;
            pos_reg    <= '0;
            sum_reg    <= '0;
            flet_reg   <= '0;
            rxflet_reg <= '0;
        end
        else if (advance)
        begin
            phase_reg  <= phase_next;
            type_reg   <= type_next;
            id_reg     <= id_next;
            len_reg    <= len_next;
            pos_reg    <= pos_next;
            sum_reg    <= sum_next;
            flet_reg   <= flet_next;
            rxflet_reg <= rxflet_next;
        end
    end

endmodule

`default_nettype wire

/* sv/sfpds_outreg.sv */
// ----------------------------------------------------------------------------
// sfpds_outreg
// Result register with valid and stall toward the downstream side.
// ----------------------------------------------------------------------------
`default_nettype none

module sfpds_outreg
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               load_valid,
    output logic                    load_ready,
    input  wire sfpds_pkg::result_t load_data,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output sfpds_pkg::result_t      out_data
);

    logic               valid_reg;
    sfpds_pkg::result_t data_reg;

    // The register can take a new item when empty or when its item leaves now.
    assign load_ready = !valid_reg || !out_stall;
    assign out_valid  = valid_reg;
    assign out_data   = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load_ready)
            valid_reg <= load_valid;
    end

    always_ff @(posedge clk)
    begin
        if (load_ready && load_valid)
            data_reg <= load_data;
    end

endmodule

`default_nettype wire

/* sv/serial_frame_parser_dual_sum_top.sv */
// ----------------------------------------------------------------------------
// serial_frame_parser_dual_sum_top
// Serial frame parser with Fletcher and sum checks over header and payload.
// ----------------------------------------------------------------------------
// Each accepted byte yields exactly one result item, and one byte can be taken
// every cycle while in_stall is low. A byte goes into an input register, the
// frame state machine and the two 8-bit running sums update from it, and the
// result lands in an output register that drives out_valid; while that register
// is full and out_stall is high, the byte waits in the input register.
// Payload bytes come out with payload_strobe and their index; the byte after
// the Fletcher byte raises frame_good or frame_bad. frame_type, frame_id and
// frame_length show the header of the current or last frame.
// ----------------------------------------------------------------------------
`default_nettype none

module serial_frame_parser_dual_sum_top
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] rx_byte,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic            payload_strobe,
    output logic [7:0]      payload_data,
    output logic [7:0]      payload_index,
    output logic            frame_good,
    output logic            frame_bad,
    output logic [7:0]      frame_type,
    output logic [7:0]      frame_id,
    output logic [7:0]      frame_length
);

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       load_ready;
    logic       advance;

    sfpds_pkg::result_t core_result;
    sfpds_pkg::result_t out_data;

    assign advance  = in_valid_reg && load_ready;
    assign in_stall = in_valid_reg && !load_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (!in_stall)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
            in_byte_reg <= rx_byte;
    end

    sfpds_parse u_parse
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .rx_byte (in_byte_reg),
        .result  (core_result)
    );

    sfpds_outreg u_outreg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_valid (in_valid_reg),
        .load_ready (load_ready),
        .load_data  (core_result),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data)
    );

    assign payload_strobe = out_data.payload_strobe;
    assign payload_data   = out_data.payload_data;
    assign payload_index  = out_data.payload_index;
    assign frame_good     = out_data.frame_good;
    assign frame_bad      = out_data.frame_bad;
    assign frame_type     = out_data.frame_type;
    assign frame_id       = out_data.frame_id;
    assign frame_length   = out_data.frame_length;

    a_verdict_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(frame_good && frame_bad))
        else $error("frame_good and frame_bad both set");

    a_verdict_not_payload: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (frame_good || frame_bad) |-> !payload_strobe)
        else $error("checksum verdict on a payload byte");

    a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && payload_strobe |-> payload_index < frame_length)
        else $error("payload index beyond frame length");

    a_held_input: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !load_ready |=> in_valid_reg && $stable(in_byte_reg))
        else $error("input register lost a waiting item");

endmodule

`default_nettype wire

/* tb/tb_serial_frame_parser_dual_sum_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_serial_frame_parser_dual_sum_top
// Self-checking bench for the serial frame parser with dual running checksum.
// ----------------------------------------------------------------------------
// Every received byte that the parser accepts is run through a frame tracker
// that keeps its own copy of the parse state and both running sums, and the
// tracker queues the result item that byte must produce. Each result item
// that leaves the parser is compared field by field with the oldest queued
// prediction. Stimulus is a short directed run (noise, a zero-length frame,
// a wrong address, a bad Fletcher byte) and then mostly well-formed frames
// with random content and random checksum damage, mixed with noise and
// broken starts. The sender idles in bursts and the receiver stalls in
// changing patterns.
// ----------------------------------------------------------------------------

module tb_serial_frame_parser_dual_sum_top;

    localparam logic [7:0] START_BYTE = 8'hA5;
    localparam logic [7:0] ADDR_BYTE  = 8'h01;
    localparam int         ITEM_GOAL  = 700;
    localparam int         DRAIN_WAIT = 8;

    typedef enum logic [3:0] {
        SEEK_START,
        WANT_ADDR,
        WANT_TYPE,
        WANT_ID,
        WANT_LEN,
        IN_PAYLOAD,
        WANT_FLET,
        WANT_SUM,
        WANT_END
    } parse_phase_e;

    typedef enum int {
        CK_INTACT,
        CK_BAD_FLETCHER,
        CK_BAD_SUM,
        CK_BAD_BOTH
    } ck_damage_e;

    typedef enum int {
        RX_FREE,
        RX_LIGHT,
        RX_HEAVY,
        RX_PERIODIC
    } rx_pattern_e;

    // Tracks the frame state the parser should be in and holds the result
    // items it still owes, oldest first.
    class frame_scoreboard;
        parse_phase_e       phase        = SEEK_START;
        logic [7:0]         held_type    = '0;
        logic [7:0]         held_id      = '0;
        logic [7:0]         held_length  = '0;
        logic [7:0]         next_index   = '0;
        logic [7:0]         run_sum      = '0;
        logic [7:0]         run_fletcher = '0;
        logic [7:0]         rx_fletcher  = '0;
        sfpds_pkg::result_t owed_results[$];
        int                 errors       = 0;

        function void add_to_sums(logic [7:0] b);
            run_sum      = run_sum + b;
            run_fletcher = run_fletcher + run_sum;
        endfunction

        function int pending();
            return owed_results.size();
        endfunction

        function void parse_rx_byte(logic [7:0] b);
            sfpds_pkg::result_t r;
            r = '0;
            case (phase)
                WANT_ADDR:
                begin
                    // A wrong address drops the frame; the byte is not
                    // looked at again as a start byte.
                    if (b == ADDR_BYTE)
                    begin
                        add_to_sums(b);
                        phase = WANT_TYPE;
                    end
                    else
                    begin
                        phase = SEEK_START;
                    end
                end
                WANT_TYPE:
                begin
                    held_type = b;
                    add_to_sums(b);
                    phase = WANT_ID;
                end
                WANT_ID:
                begin
                    held_id = b;
                    add_to_sums(b);
                    phase = WANT_LEN;
                end
                WANT_LEN:
                begin
                    held_length = b;
                    add_to_sums(b);
                    next_index = '0;
                    phase = (b == 8'd0) ? WANT_FLET : IN_PAYLOAD;
                end
                IN_PAYLOAD:
                begin
                    add_to_sums(b);
                    r.payload_strobe = 1'b1;
                    r.payload_data   = b;
                    r.payload_index  = next_index;
                    if (int'(next_index) + 1 >= int'(held_length))
                    begin
                        next_index = '0;
                        phase = WANT_FLET;
                    end
                    else
                    begin
                        next_index = next_index + 8'd1;
                    end
                end
                WANT_FLET:
                begin
                    rx_fletcher = b;
                    phase = WANT_SUM;
                end
                WANT_SUM:
                begin
                    if (b == run_sum && rx_fletcher == run_fletcher)
                        r.frame_good = 1'b1;
                    else
                        r.frame_bad = 1'b1;
                    phase = WANT_END;
                end
                WANT_END:
                begin
                    phase = SEEK_START;
                end
                default:
                begin
                    if (b == START_BYTE)
                    begin
                        run_sum      = '0;
                        run_fletcher = '0;
                        add_to_sums(b);
                        phase = WANT_ADDR;
                    end
                    else
                    begin
                        phase = SEEK_START;
                    end
                end
            endcase
            r.frame_type   = held_type;
            r.frame_id     = held_id;
            r.frame_length = held_length;
            owed_results.push_back(r);
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned seen);
            if (want != seen)
            begin
                $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, seen);
                errors++;
            end
        endfunction

        function void check_result(sfpds_pkg::result_t got);
            sfpds_pkg::result_t want;
            if (owed_results.size() == 0)
            begin
                $error("result item arrived with no prediction waiting");
                errors++;
                return;
            end
            want = owed_results.pop_front();
            compare_field("payload_strobe", want.payload_strobe, got.payload_strobe);
            compare_field("payload_data", want.payload_data, got.payload_data);
            compare_field("payload_index", want.payload_index, got.payload_index);
            compare_field("frame_good", want.frame_good, got.frame_good);
            compare_field("frame_bad", want.frame_bad, got.frame_bad);
            compare_field("frame_type", want.frame_type, got.frame_type);
            compare_field("frame_id", want.frame_id, got.frame_id);
            compare_field("frame_length", want.frame_length, got.frame_length);
        endfunction
    endclass

    logic       clk      = 1'b0;
    logic       rst_n    = 1'b0;
    logic       in_valid = 1'b0;
    logic [7:0] rx_byte  = 8'h00;
    logic       out_stall = 1'b0;
    logic       in_stall;
    logic       out_valid;
    logic       payload_strobe;
    logic [7:0] payload_data;
    logic [7:0] payload_index;
    logic       frame_good;
    logic       frame_bad;
    logic [7:0] frame_type;
    logic [7:0] frame_id;
    logic [7:0] frame_length;

    frame_scoreboard sb = new;

    int         burst_left = 0;
    int         calm_left  = 0;
    logic [7:0] tx_sum;
    logic [7:0] tx_fletcher;

    serial_frame_parser_dual_sum_top dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .payload_strobe (payload_strobe),
        .payload_data   (payload_data),
        .payload_index  (payload_index),
        .frame_good     (frame_good),
        .frame_bad      (frame_bad),
        .frame_type     (frame_type),
        .frame_id       (frame_id),
        .frame_length   (frame_length)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Accepted bytes and accepted result items, sampled at the clock edge.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            sb.parse_rx_byte(rx_byte);
        if (rst_n && out_valid && !out_stall)
            sb.check_result({payload_strobe, payload_data, payload_index, frame_good,
                             frame_bad, frame_type, frame_id, frame_length});
    end

    // The receiver switches between randomly chosen stall patterns.
    rx_pattern_e rx_pattern = RX_FREE;
    int          rx_tick    = 0;

    always @(posedge clk)
    begin
        if (rx_tick % 64 == 0)
            rx_pattern = rx_pattern_e'($urandom_range(RX_FREE, RX_PERIODIC));
        case (rx_pattern)
            RX_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
            RX_HEAVY:    out_stall <= ($urandom_range(0, 9) < 6);
            RX_PERIODIC: out_stall <= ((rx_tick % 5) < 3);
            default:     out_stall <= 1'b0;
        endcase
        rx_tick++;
    end

    // Offers one byte and returns at the edge where it was taken. Gaps are
    // only inserted between bursts, and long calm stretches have none.
    task automatic put_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = 0;
            if (calm_left == 0)
            begin
                if ($urandom_range(0, 9) == 0)
                    calm_left = 120;
                else
                    gap = $urandom_range(0, 6);
            end
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        if (calm_left > 0)
            calm_left--;
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic put_summed(input logic [7:0] b);
        tx_sum      = tx_sum + b;
        tx_fletcher = tx_fletcher + tx_sum;
        put_byte(b);
    endtask

    task automatic send_frame(input logic [7:0] ftype, input logic [7:0] fid,
                              input logic [7:0] flen, input ck_damage_e damage,
                              input logic [7:0] end_b);
        logic [7:0] flet_b;
        logic [7:0] sum_b;
        tx_sum      = '0;
        tx_fletcher = '0;
        put_summed(START_BYTE);
        put_summed(ADDR_BYTE);
        put_summed(ftype);
        put_summed(fid);
        put_summed(flen);
        for (int i = 0; i < int'(flen); i++)
            put_summed(8'($urandom));
        flet_b = tx_fletcher;
        sum_b  = tx_sum;
        if (damage == CK_BAD_FLETCHER || damage == CK_BAD_BOTH)
            flet_b = flet_b ^ 8'($urandom_range(1, 255));
        if (damage == CK_BAD_SUM || damage == CK_BAD_BOTH)
            sum_b = sum_b ^ 8'($urandom_range(1, 255));
        put_byte(flet_b);
        put_byte(sum_b);
        put_byte(end_b);
    endtask

    // Holds off the sender until the parser has delivered everything owed.
    task automatic wait_for_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int         items;
        int         pick;
        int         flen;
        int         frames;
        int         noise_len;
        bit         long_sent;
        ck_damage_e damage;
        logic [7:0] bad_addr;

        items     = 0;
        frames    = 0;
        long_sent = 1'b0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: noise while hunting, then a zero-length frame whose end
        // byte looks like a start byte.
        put_byte(8'h00);
        put_byte(8'hFF);
        send_frame(8'h00, 8'hFF, 8'd0, CK_INTACT, START_BYTE);
        // A start byte in the address slot is a wrong address, not a restart,
        // so the address byte after it is just noise.
        put_byte(START_BYTE);
        put_byte(START_BYTE);
        put_byte(ADDR_BYTE);
        send_frame(8'hFF, 8'h00, 8'd2, CK_BAD_FLETCHER, 8'h00);
        wait_for_results();

        while (items < ITEM_GOAL)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 75)
            begin
                if (!long_sent && items > ITEM_GOAL / 2)
                begin
                    flen = 255;
                    long_sent = 1'b1;
                end
                else if ($urandom_range(0, 9) == 0)
                begin
                    flen = $urandom_range(13, 40);
                end
                else
                begin
                    flen = $urandom_range(0, 12);
                end
                if ($urandom_range(0, 9) < 7)
                    damage = CK_INTACT;
                else
                    damage = ck_damage_e'($urandom_range(CK_BAD_FLETCHER, CK_BAD_BOTH));
                send_frame(8'($urandom), 8'($urandom), 8'(flen), damage, 8'($urandom));
                items += 8 + flen;
                frames++;
                if (frames % 25 == 0)
                    wait_for_results();
            end
            else if (pick < 85)
            begin
                noise_len = $urandom_range(1, 4);
                repeat (noise_len)
                    put_byte(8'($urandom));
                items += noise_len;
            end
            else
            begin
                bad_addr = 8'($urandom);
                if (bad_addr == ADDR_BYTE)
                    bad_addr = 8'h00;
                put_byte(START_BYTE);
                put_byte(bad_addr);
                items += 2;
            end
        end

        wait_for_results();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

/* files.f */
sv/sfpds_pkg.sv
sv/sfpds_parse.sv
sv/sfpds_outreg.sv
sv/serial_frame_parser_dual_sum_top.sv
tb/tb_serial_frame_parser_dual_sum_top.sv
